### design/kcc_pkg.sv
// kcc_pkg: shared types and constants for the keyword caesar cipher
package kcc_pkg;

  // alphabet size and ascii bounds of the upper-case letters
  localparam int unsigned ALPHA_N = 26;
  localparam logic [7:0]  CHAR_A  = 8'h41;
  localparam logic [7:0]  CHAR_Z  = 8'h5A;
  localparam logic [4:0]  LAST_LETTER = 5'(ALPHA_N - 1);
  localparam logic [4:0]  FULL_COUNT  = 5'(ALPHA_N);

  // request mode codes
  localparam logic [2:0] MODE_CLEAR   = 3'd0;
  localparam logic [2:0] MODE_ADD     = 3'd1;
  localparam logic [2:0] MODE_CLOSE   = 3'd2;
  localparam logic [2:0] MODE_ENCRYPT = 3'd3;
  localparam logic [2:0] MODE_DECRYPT = 3'd4;

  // configuration register index
  localparam logic REG_SHIFT = 1'b0;

  // request and result payloads
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] in_char;
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       substituted;
  } res_t;

  // classified operation carried from front to back
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ADD,
    OP_CLOSE,
    OP_ENC,
    OP_DEC
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       letter;
    logic [4:0] idx;
    logic [7:0] ch;
  } entry_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_READ,
    ST_OUT
  } st_e;

endpackage

### design/kcc_front.sv
// kcc_front: request decode and two-entry queue toward the back end
module kcc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  kcc_pkg::req_t req_i,
  output logic          q_valid_o,
  output kcc_pkg::entry_t q_data_o,
  input  logic          q_pop_i
);

  logic            mode_ok;
  kcc_pkg::entry_t ent;
  kcc_pkg::entry_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  // classify the request
  always_comb begin
    mode_ok    = 1'b1;
    ent.op     = kcc_pkg::OP_CLEAR;
    ent.ch     = req_i.in_char;
    ent.letter = (req_i.in_char >= kcc_pkg::CHAR_A) && (req_i.in_char <= kcc_pkg::CHAR_Z);
    ent.idx    = 5'(req_i.in_char - kcc_pkg::CHAR_A);
    unique case (req_i.mode)
      kcc_pkg::MODE_CLEAR:   ent.op = kcc_pkg::OP_CLEAR;
      kcc_pkg::MODE_ADD:     ent.op = kcc_pkg::OP_ADD;
      kcc_pkg::MODE_CLOSE:   ent.op = kcc_pkg::OP_CLOSE;
      kcc_pkg::MODE_ENCRYPT: ent.op = kcc_pkg::OP_ENC;
      kcc_pkg::MODE_DECRYPT: ent.op = kcc_pkg::OP_DEC;
      default:               mode_ok = 1'b0;
    endcase
  end

  assign busy      = (cnt_q == 2'd2);
  assign push      = start && !busy && mode_ok;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_data_o  = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |=> cnt_q != 2'd0) else $error("queue emptied from full in one cycle");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");

endmodule

### design/kcc_back.sv
// kcc_back: keyword alphabet tables and cipher sequencer
module kcc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [4:0]      shift_i,
  input  logic            q_valid_i,
  input  kcc_pkg::entry_t q_data_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  output kcc_pkg::res_t   res_o
);

  kcc_pkg::st_e    state_q, state_d;
  kcc_pkg::entry_t item_q;
  logic [4:0]      fwd_mem [kcc_pkg::ALPHA_N];
  logic [4:0]      inv_mem [kcc_pkg::ALPHA_N];
  logic [25:0]     seen_q;
  logic [4:0]      fill_q;
  logic            closed_q;
  logic [4:0]      cur_q;
  logic [4:0]      rd_q;
  logic            app_en, clr, close_done;
  logic [4:0]      app_idx;
  logic [4:0]      eff_shift;
  logic [5:0]      enc_sum;
  logic [4:0]      enc_addr;
  logic [5:0]      dec_val;
  logic [4:0]      dec_pos;
  logic            item_cipher;

  // shift register values past the alphabet wrap once
  assign eff_shift = (shift_i >= kcc_pkg::FULL_COUNT) ? shift_i - kcc_pkg::FULL_COUNT : shift_i;
  assign item_cipher = (item_q.op == kcc_pkg::OP_ENC) || (item_q.op == kcc_pkg::OP_DEC);

  // sequencer next state and control
  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    app_en     = 1'b0;
    app_idx    = cur_q;
    clr        = 1'b0;
    close_done = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      kcc_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_data_i.op)
            kcc_pkg::OP_CLEAR: clr = 1'b1;
            kcc_pkg::OP_ADD: begin
              app_idx = q_data_i.idx;
              app_en  = q_data_i.letter && !seen_q[q_data_i.idx] &&
                        (fill_q < kcc_pkg::FULL_COUNT);
            end
            kcc_pkg::OP_CLOSE: state_d = kcc_pkg::ST_CLOSE;
            kcc_pkg::OP_ENC, kcc_pkg::OP_DEC: begin
              if (!closed_q)               state_d = kcc_pkg::ST_CLOSE;
              else if (q_data_i.letter)    state_d = kcc_pkg::ST_READ;
              else                         state_d = kcc_pkg::ST_OUT;
            end
            default: ;
          endcase
        end
      end
      kcc_pkg::ST_CLOSE: begin
        app_en = !seen_q[cur_q] && (fill_q < kcc_pkg::FULL_COUNT);
        if (cur_q == kcc_pkg::LAST_LETTER) begin
          close_done = 1'b1;
          if (!item_cipher)       state_d = kcc_pkg::ST_IDLE;
          else if (item_q.letter) state_d = kcc_pkg::ST_READ;
          else                    state_d = kcc_pkg::ST_OUT;
        end
      end
      kcc_pkg::ST_READ: state_d = kcc_pkg::ST_OUT;
      kcc_pkg::ST_OUT: begin
        res_valid_o = 1'b1;
        state_d     = kcc_pkg::ST_IDLE;
      end
      default: state_d = kcc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= kcc_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // latch the popped request
  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_data_i;
  end

  // keyword bookkeeping and close walk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      fill_q   <= '0;
      closed_q <= 1'b0;
      cur_q    <= '0;
    end else begin
      if (clr) begin
        seen_q   <= '0;
        fill_q   <= '0;
        closed_q <= 1'b0;
      end else begin
        if (app_en) begin
          seen_q[app_idx] <= 1'b1;
          fill_q          <= fill_q + 5'd1;
        end
        if (close_done) closed_q <= 1'b1;
      end
      if (state_q == kcc_pkg::ST_CLOSE) cur_q <= cur_q + 5'd1;
      else                              cur_q <= '0;
    end
  end

  // forward table (position -> letter) and inverse table (letter -> position)
  always_ff @(posedge clk_i) begin
    if (app_en) begin
      fwd_mem[fill_q]  <= app_idx;
      inv_mem[app_idx] <= fill_q;
    end
  end

  // table lookup for the current cipher request
  assign enc_sum  = 6'(item_q.idx) + 6'(eff_shift);
  assign enc_addr = (enc_sum >= 6'(kcc_pkg::ALPHA_N)) ? 5'(enc_sum - 6'(kcc_pkg::ALPHA_N))
                                                      : enc_sum[4:0];
  always_ff @(posedge clk_i) begin
    if (state_q == kcc_pkg::ST_READ) begin
      rd_q <= (item_q.op == kcc_pkg::OP_ENC) ? fwd_mem[enc_addr] : inv_mem[item_q.idx];
    end
  end

  // result formation
  assign dec_val = (rd_q >= eff_shift) ? 6'(rd_q) - 6'(eff_shift)
                                       : 6'(rd_q) + 6'(kcc_pkg::ALPHA_N) - 6'(eff_shift);
  assign dec_pos = dec_val[4:0];
  always_comb begin
    res_o.substituted = item_q.letter;
    if (!item_q.letter)                  res_o.out_char = item_q.ch;
    else if (item_q.op == kcc_pkg::OP_ENC) res_o.out_char = kcc_pkg::CHAR_A + 8'(rd_q);
    else                                 res_o.out_char = kcc_pkg::CHAR_A + 8'(dec_pos);
  end

  a_fill_matches_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    5'($countones(seen_q)) == fill_q) else $error("fill count disagrees with seen letters");
  a_closed_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> (fill_q == kcc_pkg::FULL_COUNT) && (&seen_q))
    else $error("alphabet closed without every letter");
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("back-to-back results from one request");
  a_result_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> closed_q) else $error("result produced from an open alphabet");

endmodule

### design/keyword_caesar_cipher.sv
// keyword_caesar_cipher: top level with configuration port, front queue and back end
//
//   channel   direction  handshake                  payload
//   request   in         start & !busy              req_i   (mode, in_char)
//   result    out        res_valid_o, one cycle     res_o   (out_char, substituted)
//   config    in         psel & penable & pwrite    pwdata  (shift at byte address 0)
//
// clear and add-letter are done as they are popped; close is popped, then walks the
// 26 letters, one a cycle
// encrypt and decrypt of a letter go through pop, table read and result, other
// bytes through pop and result, after the close walk when the alphabet must be closed first
// the front queue holds two requests, busy is high while it is full
// reset clears the keyword state, shift and queue; table contents are defined by writes
// results cannot be held off: the strobe lasts exactly one cycle
module keyword_caesar_cipher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  kcc_pkg::req_t req_i,
  output logic          res_valid_o,
  output kcc_pkg::res_t res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic            q_valid, q_pop;
  kcc_pkg::entry_t q_data;
  logic [4:0]      shift_q;
  logic            reg_hit;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == kcc_pkg::REG_SHIFT) && (paddr[1:0] == 2'b00);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      shift_q <= pwdata[4:0];
    end
  end
  assign prdata = reg_hit ? {27'd0, shift_q} : 32'd0;

  // request decode and queue
  kcc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  // table keeping and cipher execution
  kcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (shift_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

### bench/keyword_caesar_cipher_tb.sv
// keyword_caesar_cipher_tb: self-checking bench with keyword, cipher and shift traffic
module keyword_caesar_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 100;
  localparam int ITEMS_PER_PHASE = 55;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  kcc_pkg::req_t req_i = '0;
  logic          res_valid_o;
  kcc_pkg::res_t res_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  keyword_caesar_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk_i = ~clk_i;

  // keyword alphabet state mirrored by the bench
  logic [4:0]                  alpha_map [kcc_pkg::ALPHA_N];
  logic [kcc_pkg::ALPHA_N-1:0] seen_mask = '0;
  int                          fill_n = 0;
  bit                          alpha_closed = 1'b0;
  logic [4:0]                  shift_cfg = '0;

  kcc_pkg::req_t pending_req_q [$];
  kcc_pkg::res_t cipher_out_q [$];
  int   mismatch_n = 0;
  int   live_n = 0;
  int   burst_left = 1;
  int   gap_left = 0;

  initial begin
    foreach (alpha_map[i]) alpha_map[i] = '0;
  end

  function automatic bit is_letter(logic [7:0] ch);
    return ch >= kcc_pkg::CHAR_A && ch <= kcc_pkg::CHAR_Z;
  endfunction

  function automatic void append_letter(int idx);
    if (idx < kcc_pkg::ALPHA_N && !seen_mask[idx] && fill_n < kcc_pkg::ALPHA_N) begin
      alpha_map[fill_n] = 5'(idx);
      fill_n++;
      seen_mask[idx] = 1'b1;
    end
  endfunction

  function automatic void close_alphabet();
    for (int i = 0; i < kcc_pkg::ALPHA_N; i++) append_letter(i);
    alpha_closed = 1'b1;
  endfunction

  // update the alphabet state for one request and queue the cipher output it gives
  function automatic void advance_cipher(kcc_pkg::req_t r);
    int            s;
    int            idx;
    bit            found;
    kcc_pkg::res_t exp_res;
    s = (shift_cfg >= kcc_pkg::ALPHA_N) ? int'(shift_cfg) - kcc_pkg::ALPHA_N
                                        : int'(shift_cfg);
    found = 1'b0;
    case (r.mode)
      kcc_pkg::MODE_CLEAR: begin
        seen_mask = '0;
        fill_n = 0;
        alpha_closed = 1'b0;
      end
      kcc_pkg::MODE_ADD: begin
        if (is_letter(r.in_char)) append_letter(int'(r.in_char - kcc_pkg::CHAR_A));
      end
      kcc_pkg::MODE_CLOSE: begin
        close_alphabet();
      end
      kcc_pkg::MODE_ENCRYPT, kcc_pkg::MODE_DECRYPT: begin
        if (!alpha_closed) close_alphabet();
        exp_res.out_char = r.in_char;
        exp_res.substituted = 1'b0;
        if (is_letter(r.in_char)) begin
          if (r.mode == kcc_pkg::MODE_ENCRYPT) begin
            idx = int'(r.in_char - kcc_pkg::CHAR_A) + s;
            if (idx >= kcc_pkg::ALPHA_N) idx -= kcc_pkg::ALPHA_N;
            exp_res.out_char = kcc_pkg::CHAR_A + 8'(alpha_map[idx]);
            exp_res.substituted = 1'b1;
          end else begin
            for (int i = 0; i < kcc_pkg::ALPHA_N; i++) begin
              if (!found && alpha_map[i] == 5'(r.in_char - kcc_pkg::CHAR_A)) begin
                found = 1'b1;
                idx = (i >= s) ? i - s : i + kcc_pkg::ALPHA_N - s;
                exp_res.out_char = kcc_pkg::CHAR_A + 8'(idx);
                exp_res.substituted = 1'b1;
              end
            end
          end
        end
        cipher_out_q.push_back(exp_res);
      end
      default: ;
    endcase
  endfunction

  // request driver: bursts with random gaps, holds a request until it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) advance_cipher(req_i);
      if (start && busy) begin
        // hold the current request
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_req_q.size() != 0) begin
        req_i <= pending_req_q.pop_front();
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (cipher_out_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got out_char %h substituted %b",
                 $time, res_o.out_char, res_o.substituted);
        mismatch_n++;
      end else begin
        if (res_o.out_char !== cipher_out_q[0].out_char) begin
          $display("%0t: out_char mismatch, expected %h, got %h",
                   $time, cipher_out_q[0].out_char, res_o.out_char);
          mismatch_n++;
        end
        if (res_o.substituted !== cipher_out_q[0].substituted) begin
          $display("%0t: substituted mismatch, expected %b, got %b",
                   $time, cipher_out_q[0].substituted, res_o.substituted);
          mismatch_n++;
        end
        void'(cipher_out_q.pop_front());
      end
    end
  end

  task automatic queue_req(logic [2:0] mode, logic [7:0] ch);
    kcc_pkg::req_t r;
    r.mode = mode;
    r.in_char = ch;
    pending_req_q.push_back(r);
    if (mode <= kcc_pkg::MODE_DECRYPT) live_n++;
  endtask

  // mostly upper-case letters, sometimes any byte
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 4) != 0) begin
      return kcc_pkg::CHAR_A + 8'($urandom_range(0, kcc_pkg::ALPHA_N - 1));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // clear, keyword, optional close, then a message
  task automatic queue_keyed_message();
    int n_key;
    int n_msg;
    n_key = $urandom_range(0, 10);
    n_msg = $urandom_range(1, 14);
    queue_req(kcc_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)));
    repeat (n_key) queue_req(kcc_pkg::MODE_ADD, pick_char());
    if ($urandom_range(0, 1) != 0) queue_req(kcc_pkg::MODE_CLOSE, 8'($urandom_range(0, 255)));
    repeat (n_msg) begin
      queue_req(($urandom_range(0, 1) != 0) ? kcc_pkg::MODE_ENCRYPT : kcc_pkg::MODE_DECRYPT,
                pick_char());
    end
  endtask

  // any mode, any byte
  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) queue_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_phase();
    int goal;
    goal = live_n + ITEMS_PER_PHASE;
    while (live_n < goal) begin
      if ($urandom_range(0, 6) != 0) queue_keyed_message();
      else queue_noise();
    end
  endtask

  // wait until every request is taken and answered, then let the block go quiet
  task automatic settle();
    while (pending_req_q.size() != 0 || start || cipher_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_shift(logic [4:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {kcc_pkg::REG_SHIFT, 2'b00};
    pwdata <= ($urandom() & ~32'h1F) | 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shift_cfg = val;
  endtask

  // main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: keyword edge cases, implicit close, pass-through bytes, spare modes
    queue_req(kcc_pkg::MODE_ADD, kcc_pkg::CHAR_Z);
    queue_req(kcc_pkg::MODE_ADD, kcc_pkg::CHAR_A);
    queue_req(kcc_pkg::MODE_ADD, kcc_pkg::CHAR_Z);
    queue_req(kcc_pkg::MODE_ADD, 8'h61);
    queue_req(kcc_pkg::MODE_ADD, 8'h00);
    queue_req(kcc_pkg::MODE_ADD, 8'hFF);
    queue_req(kcc_pkg::MODE_ADD, kcc_pkg::CHAR_A + 8'd10);
    queue_req(kcc_pkg::MODE_ENCRYPT, kcc_pkg::CHAR_A);
    queue_req(kcc_pkg::MODE_ENCRYPT, kcc_pkg::CHAR_Z);
    queue_req(kcc_pkg::MODE_DECRYPT, kcc_pkg::CHAR_A);
    queue_req(kcc_pkg::MODE_DECRYPT, kcc_pkg::CHAR_Z);
    queue_req(kcc_pkg::MODE_ENCRYPT, 8'h00);
    queue_req(kcc_pkg::MODE_ENCRYPT, 8'hFF);
    queue_req(kcc_pkg::MODE_DECRYPT, kcc_pkg::CHAR_A - 8'd1);
    queue_req(kcc_pkg::MODE_DECRYPT, kcc_pkg::CHAR_Z + 8'd1);
    queue_req(kcc_pkg::MODE_ENCRYPT, 8'h61);
    queue_req(kcc_pkg::MODE_ADD, kcc_pkg::CHAR_A + 8'd16);
    queue_req(kcc_pkg::MODE_CLOSE, 8'h00);
    queue_req(kcc_pkg::MODE_DECRYPT + 3'd1, kcc_pkg::CHAR_A);
    queue_req(kcc_pkg::MODE_DECRYPT + 3'd2, 8'hFF);
    queue_req(kcc_pkg::MODE_DECRYPT + 3'd3, kcc_pkg::CHAR_Z);
    queue_req(kcc_pkg::MODE_CLEAR, 8'hFF);
    queue_req(kcc_pkg::MODE_DECRYPT, 8'h20);
    queue_req(kcc_pkg::MODE_CLEAR, 8'h00);
    queue_req(kcc_pkg::MODE_CLOSE, 8'hFF);
    queue_req(kcc_pkg::MODE_CLOSE, 8'h00);
    queue_req(kcc_pkg::MODE_ENCRYPT, kcc_pkg::CHAR_A + 8'd12);
    queue_phase();
    settle();

    // shift settings: extremes, wrapped values and random ones
    write_shift(5'd25);
    queue_phase();
    settle();
    write_shift(5'd0);
    queue_phase();
    settle();
    write_shift(5'(kcc_pkg::ALPHA_N + $urandom_range(0, 5)));
    queue_phase();
    settle();
    write_shift(5'd31);
    queue_phase();
    settle();
    write_shift(5'($urandom_range(1, 24)));
    queue_phase();
    settle();
    write_shift(5'($urandom_range(0, 31)));
    queue_phase();
    settle();

    if (mismatch_n == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
